FILE: rtl/core/pse_pkg.sv
// pse_pkg: shared widths, constants, types and the exp(-lambda) table builder
// for the poisson spike encoder. No dependencies.
package pse_pkg;

  localparam int CHANNELS          = 256;
  localparam int EXP_TABLE_ENTRIES = 1024;
  localparam int MAX_SPIKES        = 64;

  localparam int CH_W       = 8;
  localparam int SAMPLE_W   = 16;
  localparam int RATE_W     = 16;
  localparam int STEP_W     = 20;
  localparam int SEED_W     = 48;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;
  localparam int THR_W      = 32;
  localparam int LAM_W      = 24;
  localparam int COUNT_W    = $clog2(MAX_SPIKES + 1);
  localparam int ROM_AW     = $clog2(EXP_TABLE_ENTRIES);
  localparam int SPAN_SHIFT = 21;

  localparam int QUEUE_DEPTH  = 8;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int FRONT_STAGES = 8;
  localparam int PCNT_W       = $clog2(FRONT_STAGES + 1);

  localparam logic [23:0]       LCG_MUL_LO = 24'hECE66D;
  localparam logic [10:0]       LCG_MUL_HI = 11'h5DE;
  localparam logic [SEED_W-1:0] LCG_ADD    = 48'hB;

  localparam logic [RATE_W-1:0]   RATE_MIN_RESET = 16'd0;
  localparam logic [RATE_W-1:0]   RATE_MAX_RESET = 16'd100;
  localparam logic [STEP_W-1:0]   STEP_RESET     = 20'd1000;
  localparam logic [SEED_W-1:0]   SEED_RESET     = 48'd4660;
  localparam logic [SAMPLE_W-1:0] SAMPLE_OFFSET  = 16'h8000;

  localparam logic [63:0] ONE_Q60      = 64'd1 << 60;
  localparam int          TAYLOR_TERMS = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE_MIN = 2'd0,
    CFG_RATE_MAX = 2'd1,
    CFG_STEP     = 2'd2,
    CFG_SEED     = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [RATE_W-1:0] rate_min_hz;
    logic [RATE_W-1:0] rate_max_hz;
    logic [STEP_W-1:0] step_us;
  } cfg_t;

  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [THR_W-1:0] thr;
  } job_t;

  typedef struct packed {
    logic [CH_W-1:0]    ch;
    logic [COUNT_W-1:0] count;
    logic               sat;
  } run_t;

  typedef logic [THR_W-1:0] exp_rom_t [EXP_TABLE_ENTRIES];

  // entry i is exp(-i*32/entries) in q0.32, built by repeated q2.60 products
  function automatic exp_rom_t build_exp_rom();
    exp_rom_t     rom;
    logic [63:0]  d;
    logic [63:0]  r;
    logic [63:0]  term;
    logic [63:0]  e;
    logic [63:0]  v;
    logic [127:0] prod;
    d    = ((64'd1 << 63) / 64'(EXP_TABLE_ENTRIES)) << 2;
    r    = ONE_Q60;
    term = ONE_Q60;
    e    = ONE_Q60;
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      prod = {64'd0, term} * {64'd0, d};
      term = prod[123:60] / 64'(n);
      if ((n % 2) == 1) begin
        r = r - term;
      end else begin
        r = r + term;
      end
    end
    for (int i = 0; i < EXP_TABLE_ENTRIES; i++) begin
      v = (e + (64'd1 << 27)) >> 28;
      rom[i] = (v > 64'h0000_0000_FFFF_FFFF) ? '1 : v[THR_W-1:0];
      prod = {64'd0, e} * {64'd0, r};
      e = prod[123:60];
    end
    return rom;
  endfunction

endpackage

FILE: rtl/core/pse_front.sv
// pse_front: takes sample items, maps them to lambda and looks up the
// exp(-lambda) threshold over an eight stage pipeline. Depends on pse_pkg.
module pse_front (
  input  logic                          clk,
  input  logic                          rst,
  input  pse_pkg::cfg_t                 cfg,
  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  logic [pse_pkg::CH_W-1:0]      channel,
  input  logic [pse_pkg::SAMPLE_W-1:0]  sample,
  input  logic [pse_pkg::QCNT_W-1:0]    q_count,
  output logic                          job_push,
  output pse_pkg::job_t                 job
);
  import pse_pkg::*;

  localparam exp_rom_t EXP_ROM = build_exp_rom();

  // lambda = floor((rate*step + 500000) / 1e6), done as >>6 then /15625
  localparam int V_W           = 52;
  localparam int DIV_PRE_SHIFT = 6;
  localparam int W_W           = 38;
  localparam int W_LO          = 19;
  localparam int M_W           = 39;
  localparam int M_LO          = 20;
  localparam int RECIP_SHIFT   = 52;
  localparam int QSUM_W        = 77;
  localparam logic [63:0]    RECIP_M64     = ((64'd1 << RECIP_SHIFT) + 64'd15624) / 64'd15625;
  localparam logic [M_W-1:0] RECIP_M       = RECIP_M64[M_W-1:0];
  localparam logic [V_W-1:0] ROUND_HALF    = 52'd500000;
  localparam logic [63:0]    LAM_SAT_LIM64 = (64'd1 << LAM_W) * 64'd1000000;
  localparam logic [V_W-1:0] LAM_SAT_LIM   = LAM_SAT_LIM64[V_W-1:0];
  localparam int IDX_PROD_W = LAM_W + $clog2(EXP_TABLE_ENTRIES + 1);
  localparam int IDX_FULL_W = IDX_PROD_W - SPAN_SHIFT;

  logic [FRONT_STAGES-1:0] vld;
  logic [PCNT_W-1:0]       pipe_count;
  logic [CH_W-1:0]         ch_pipe [FRONT_STAGES];
  logic                    enter;
  logic                    ch_ok;

  logic [SAMPLE_W-1:0] s1_sample;
  logic [31:0]         s2_rate;
  logic [V_W-1:0]      s3_prod;
  logic [W_W-1:0]      s4_w;
  logic                s4_big;
  logic                s5_big;
  logic [37:0]         s5_pp_hh;
  logic [38:0]         s5_pp_hl;
  logic [37:0]         s5_pp_lh;
  logic [38:0]         s5_pp_ll;
  logic [LAM_W-1:0]    s6_lam;
  logic [ROM_AW-1:0]   s7_addr;
  logic                s7_oob;
  logic [THR_W-1:0]    s8_rom;
  logic                s8_oob;

  logic signed [16:0]    u_s;
  logic signed [16:0]    diff_s;
  logic signed [33:0]    rprod_s;
  logic signed [33:0]    rate_s;
  logic [31:0]           rate_q16;
  logic [V_W-1:0]        vprod;
  logic [V_W-1:0]        vsum;
  logic [QSUM_W-1:0]     qsum;
  logic [IDX_PROD_W-1:0] idx_prod;
  logic [IDX_FULL_W-1:0] idx_full;
  logic                  idx_oob;

  // only as many items in flight as the queue can still hold
  assign sample_stall = ({1'b0, pipe_count} + {1'b0, q_count}) >=
                        (PCNT_W + 1)'(QUEUE_DEPTH);
  assign ch_ok = {24'd0, channel} < 32'(CHANNELS);
  assign enter = sample_valid && !sample_stall && ch_ok;

  always_comb begin
    u_s      = signed'({1'b0, s1_sample ^ SAMPLE_OFFSET});
    diff_s   = signed'({1'b0, cfg.rate_max_hz}) - signed'({1'b0, cfg.rate_min_hz});
    rprod_s  = 34'(u_s) * 34'(diff_s);
    rate_s   = rprod_s + signed'({2'b00, cfg.rate_min_hz, 16'd0});
    rate_q16 = rate_s[33] ? '0 : rate_s[31:0];
    vprod    = V_W'(s2_rate) * V_W'(cfg.step_us);
    vsum     = s3_prod + ROUND_HALF;
    qsum     = {s5_pp_hh, 39'd0} + {19'd0, s5_pp_hl, 19'd0} +
               {19'd0, s5_pp_lh, 20'd0} + {38'd0, s5_pp_ll};
    idx_prod = IDX_PROD_W'(s6_lam) * IDX_PROD_W'(EXP_TABLE_ENTRIES);
    idx_full = idx_prod[IDX_PROD_W-1:SPAN_SHIFT];
    idx_oob  = idx_full >= IDX_FULL_W'(EXP_TABLE_ENTRIES);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld        <= '0;
      pipe_count <= '0;
    end else begin
      vld        <= {vld[FRONT_STAGES-2:0], enter};
      pipe_count <= pipe_count + PCNT_W'(enter) - PCNT_W'(vld[FRONT_STAGES-1]);
    end
  end

  always_ff @(posedge clk) begin
    ch_pipe[0] <= channel;
    for (int i = 1; i < FRONT_STAGES; i++) begin
      ch_pipe[i] <= ch_pipe[i-1];
    end
    s1_sample <= sample;
    s2_rate   <= rate_q16;
    s3_prod   <= vprod;
    s4_big    <= vsum >= LAM_SAT_LIM;
    s4_w      <= vsum[DIV_PRE_SHIFT +: W_W];
    s5_big    <= s4_big;
    s5_pp_hh  <= 38'(s4_w[W_W-1:W_LO]) * 38'(RECIP_M[M_W-1:M_LO]);
    s5_pp_hl  <= 39'(s4_w[W_W-1:W_LO]) * 39'(RECIP_M[M_LO-1:0]);
    s5_pp_lh  <= 38'(s4_w[W_LO-1:0]) * 38'(RECIP_M[M_W-1:M_LO]);
    s5_pp_ll  <= 39'(s4_w[W_LO-1:0]) * 39'(RECIP_M[M_LO-1:0]);
    s6_lam    <= s5_big ? '1 : qsum[RECIP_SHIFT +: LAM_W];
    s7_oob    <= idx_oob;
    s7_addr   <= idx_oob ? '0 : idx_full[ROM_AW-1:0];
    s8_oob    <= s7_oob;
    s8_rom    <= EXP_ROM[s7_addr];
  end

  assign job_push = vld[FRONT_STAGES-1];
  assign job.ch   = ch_pipe[FRONT_STAGES-1];
  assign job.thr  = s8_oob ? '0 : s8_rom;

endmodule

FILE: rtl/core/pse_fifo.sv
// pse_fifo: short queue of threshold jobs between front end and draw engine.
// Depends on pse_pkg.
module pse_fifo (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  pse_pkg::job_t              push_data,
  input  logic                       pop,
  output pse_pkg::job_t              head,
  output logic [pse_pkg::QCNT_W-1:0] count
);
  import pse_pkg::*;

  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  assign head = mem[rd_ptr];

endmodule

FILE: rtl/core/pse_draw.sv
// pse_draw: draw engine; steps the 48-bit lcg and multiplies uniforms into the
// running product until it falls to the threshold or the cap. Depends on pse_pkg.
module pse_draw (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [pse_pkg::QCNT_W-1:0] q_count,
  input  pse_pkg::job_t              head,
  output logic                       pop,
  input  logic                       seed_load,
  input  logic [pse_pkg::SEED_W-1:0] seed_value,
  output logic                       run_valid,
  output pse_pkg::run_t              run,
  input  logic                       run_ready
);
  import pse_pkg::*;

  typedef enum logic [5:0] {
    D_IDLE = 6'b000001,
    D_GMUL = 6'b000010,
    D_XUP  = 6'b000100,
    D_PMUL = 6'b001000,
    D_CMP  = 6'b010000,
    D_HAND = 6'b100000
  } draw_state_t;

  draw_state_t state;
  draw_state_t state_next;

  logic [SEED_W-1:0]  x;
  logic [SEED_W-1:0]  x_next;
  logic [SEED_W-1:0]  p;
  logic [THR_W-1:0]   thr;
  logic [CH_W-1:0]    ch;
  logic [COUNT_W-1:0] n;
  logic               first;

  // lcg partial products of a*x mod 2^48
  logic [47:0] g_ll;
  logic [23:0] g_lh;
  logic [23:0] g_hl;
  // partial products of p*x
  logic [47:0] p_hh;
  logic [47:0] p_hl;
  logic [47:0] p_lh;
  logic [47:0] p_ll;

  logic [95:0]       psum;
  logic [SEED_W-1:0] p_new;
  logic              hit;

  assign x_next = g_ll + {g_lh + g_hl, 24'd0} + LCG_ADD;
  assign psum   = {p_hh, 48'd0} + {24'd0, p_hl, 24'd0} + {24'd0, p_lh, 24'd0} +
                  {48'd0, p_ll};
  // the product starts at one, so the first draw's product is the uniform
  assign p_new  = first ? x : psum[95:48];
  assign hit    = p_new > {thr, 16'd0};
  assign pop    = (state == D_IDLE) && (q_count != '0);

  assign run_valid = (state == D_HAND);
  assign run.ch    = ch;
  assign run.count = n;
  assign run.sat   = (n == COUNT_W'(MAX_SPIKES));

  always_comb begin
    state_next = state;
    unique case (state)
      D_IDLE: if (pop) state_next = D_GMUL;
      D_GMUL: state_next = D_XUP;
      D_XUP:  state_next = D_PMUL;
      D_PMUL: state_next = D_CMP;
      D_CMP: begin
        if (hit) begin
          state_next = (n == COUNT_W'(MAX_SPIKES - 1)) ? D_HAND : D_XUP;
        end else begin
          state_next = (n == '0) ? D_IDLE : D_HAND;
        end
      end
      D_HAND: if (run_ready) state_next = D_IDLE;
      default: state_next = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      x     <= SEED_RESET;
      n     <= '0;
      first <= 1'b1;
    end else begin
      state <= state_next;
      if (seed_load) begin
        x <= seed_value;
      end else if (state == D_XUP) begin
        x <= x_next;
      end
      if (pop) begin
        n     <= '0;
        first <= 1'b1;
      end else if (state == D_CMP && hit) begin
        n     <= n + 1'b1;
        first <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ch  <= head.ch;
      thr <= head.thr;
    end
    // next lcg step is prepared while the product is formed
    if (state == D_GMUL || state == D_PMUL) begin
      g_ll <= 48'(LCG_MUL_LO) * 48'(x[23:0]);
      g_lh <= LCG_MUL_LO * x[47:24];
      g_hl <= 24'(LCG_MUL_HI) * x[23:0];
    end
    if (state == D_PMUL) begin
      p_hh <= 48'(p[47:24]) * 48'(x[47:24]);
      p_hl <= 48'(p[47:24]) * 48'(x[23:0]);
      p_lh <= 48'(p[23:0]) * 48'(x[47:24]);
      p_ll <= 48'(p[23:0]) * 48'(x[23:0]);
    end
    if (state == D_CMP && hit) begin
      p <= p_new;
    end
  end

endmodule

FILE: rtl/core/pse_emit.sv
// pse_emit: output stage; turns one finished run into its spike items.
// Depends on pse_pkg.
module pse_emit (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     run_valid,
  input  pse_pkg::run_t            run,
  output logic                     run_ready,
  output logic                     spike_valid,
  input  logic                     spike_stall,
  output logic [pse_pkg::CH_W-1:0] spike_channel,
  output logic                     spike_last,
  output logic                     saturated
);
  import pse_pkg::*;

  logic [COUNT_W-1:0] rem;
  logic [CH_W-1:0]    ch_q;
  logic               sat_q;
  logic               take;

  // a new run loads once the current one is out or its last item leaves now
  assign run_ready = (rem == '0) || (rem == COUNT_W'(1) && !spike_stall);
  assign take      = run_valid && run_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= '0;
    end else if (take) begin
      rem <= run.count;
    end else if (spike_valid && !spike_stall) begin
      rem <= rem - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ch_q  <= run.ch;
      sat_q <= run.sat;
    end
  end

  assign spike_valid   = (rem != '0);
  assign spike_channel = ch_q;
  assign spike_last    = (rem == COUNT_W'(1));
  assign saturated     = sat_q;

endmodule

FILE: rtl/core/poisson_spike_encoder.sv
// poisson_spike_encoder: top level; config registers, front end, job queue,
// draw engine and output stage. Depends on pse_pkg and the pse_* modules.
// Front end takes one item per cycle while sample_stall is low, up to 8 in flight.
// Draw engine works on one item at a time: GMUL, then XUP, PMUL and CMP per draw,
// then HAND when the run has spikes; spikes then leave 1/cycle unless stalled.
// Synchronous reset clears pipeline, queue and sequencer, loads register
// defaults and seeds the lcg with 4660; no clearing pass.
module poisson_spike_encoder (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [pse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pse_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           sample_valid,
  output logic                           sample_stall,
  input  logic [pse_pkg::CH_W-1:0]       channel,
  input  logic [pse_pkg::SAMPLE_W-1:0]   sample,
  output logic                           spike_valid,
  input  logic                           spike_stall,
  output logic [pse_pkg::CH_W-1:0]       spike_channel,
  output logic                           spike_last,
  output logic                           saturated
);
  import pse_pkg::*;

  cfg_t              cfg;
  logic              seed_load;
  logic              job_push;
  job_t              job;
  job_t              head;
  logic              pop;
  logic [QCNT_W-1:0] q_count;
  logic              run_valid;
  logic              run_ready;
  run_t              run;

  assign seed_load = cfg_wr_en && (cfg_idx_t'(cfg_index) == CFG_SEED);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.rate_min_hz <= RATE_MIN_RESET;
      cfg.rate_max_hz <= RATE_MAX_RESET;
      cfg.step_us     <= STEP_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RATE_MIN: cfg.rate_min_hz <= cfg_data[RATE_W-1:0];
        CFG_RATE_MAX: cfg.rate_max_hz <= cfg_data[RATE_W-1:0];
        CFG_STEP:     cfg.step_us     <= cfg_data[STEP_W-1:0];
        CFG_SEED:     ; // seed goes straight into the lcg state
        default:      ;
      endcase
    end
  end

  pse_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .channel      (channel),
    .sample       (sample),
    .q_count      (q_count),
    .job_push     (job_push),
    .job          (job)
  );

  pse_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (job_push),
    .push_data (job),
    .pop       (pop),
    .head      (head),
    .count     (q_count)
  );

  pse_draw u_draw (
    .clk        (clk),
    .rst        (rst),
    .q_count    (q_count),
    .head       (head),
    .pop        (pop),
    .seed_load  (seed_load),
    .seed_value (cfg_data[SEED_W-1:0]),
    .run_valid  (run_valid),
    .run        (run),
    .run_ready  (run_ready)
  );

  pse_emit u_emit (
    .clk           (clk),
    .rst           (rst),
    .run_valid     (run_valid),
    .run           (run),
    .run_ready     (run_ready),
    .spike_valid   (spike_valid),
    .spike_stall   (spike_stall),
    .spike_channel (spike_channel),
    .spike_last    (spike_last),
    .saturated     (saturated)
  );

endmodule

FILE: rtl/core/pse_checker.sv
// pse_checker: port-level checks on the spike output of the encoder, and the
// bind that attaches them to the top level. Depends on pse_pkg.
module pse_checker (
  input logic                     clk,
  input logic                     rst,
  input logic                     spike_valid,
  input logic                     spike_stall,
  input logic [pse_pkg::CH_W-1:0] spike_channel,
  input logic                     spike_last,
  input logic                     saturated
);
  import pse_pkg::*;

  logic [COUNT_W-1:0] run_pos;
  logic               take;

  assign take = spike_valid && !spike_stall;

  // position of the current item within its run
  always_ff @(posedge clk) begin
    if (rst) begin
      run_pos <= '0;
    end else if (take) begin
      run_pos <= spike_last ? '0 : run_pos + 1'b1;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    spike_valid && spike_stall |=> spike_valid && $stable(spike_channel) &&
      $stable(spike_last) && $stable(saturated))
    else $error("spike item changed while stalled");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    take && !spike_last |=> spike_valid && $stable(spike_channel) && $stable(saturated))
    else $error("run broken before its last item");

  a_sat_length: assert property (@(posedge clk) disable iff (rst)
    spike_valid && spike_last && saturated |-> run_pos == COUNT_W'(MAX_SPIKES - 1))
    else $error("saturated run does not end at the cap");

  a_unsat_length: assert property (@(posedge clk) disable iff (rst)
    spike_valid && !saturated |-> run_pos != COUNT_W'(MAX_SPIKES - 1))
    else $error("unsaturated run reached the cap");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !spike_valid)
    else $error("spike item shown right after reset");

endmodule

bind poisson_spike_encoder pse_checker u_pse_checker (
  .clk           (clk),
  .rst           (rst),
  .spike_valid   (spike_valid),
  .spike_stall   (spike_stall),
  .spike_channel (spike_channel),
  .spike_last    (spike_last),
  .saturated     (saturated)
);

FILE: verif/testbench.sv
// testbench: self-checking bench for poisson_spike_encoder, directed table then random
// phases under mixed idle and stall, every spike checked against an internal predictor.
// Depends on pse_pkg and the poisson_spike_encoder RTL.
module testbench;
  import pse_pkg::*;

  localparam logic [47:0] LCG_MULT      = 48'h5_DEEC_E66D;
  localparam logic [47:0] LCG_INC       = 48'hB;
  localparam int          PREDICTED     = -1;
  localparam int          SETTLE_CYCLES = 200;
  localparam int          TAIL_CYCLES   = 300;
  localparam int          QUIET_LIMIT   = 4000;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
    logic            sat;
  } spike_t;

  typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    cfg_idx_t           idx;
    logic [47:0]        value;
    logic [CH_W-1:0]    ch;
    logic [SAMPLE_W-1:0] smp;
    int                 count;
  } stim_row_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en = 1'b0;
  cfg_idx_t              cfg_index = CFG_RATE_MIN;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  sample_valid = 1'b0;
  logic                  sample_stall;
  logic [CH_W-1:0]       channel = '0;
  logic [SAMPLE_W-1:0]   sample = '0;
  logic                  spike_valid;
  logic                  spike_stall = 1'b0;
  logic [CH_W-1:0]       spike_channel;
  logic                  spike_last;
  logic                  saturated;

  // predictor state
  logic [31:0] exp_table [EXP_TABLE_ENTRIES];
  logic [15:0] m_rate_min;
  logic [15:0] m_rate_max;
  logic [19:0] m_step;
  logic [47:0] m_lcg;
  spike_t      pending_spikes [$];

  int typed_count = PREDICTED;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int errors = 0;
  int quiet = 0;
  int samples_in = 0;
  int empty_runs = 0;
  int capped_runs = 0;
  int spikes_seen = 0;
  int writes_done = 0;

  poisson_spike_encoder dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .channel      (channel),
    .sample       (sample),
    .spike_valid  (spike_valid),
    .spike_stall  (spike_stall),
    .spike_channel(spike_channel),
    .spike_last   (spike_last),
    .saturated    (saturated)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int unsigned sh);
    logic [127:0] full;
    full = a;
    full = full * b;
    full = full >> sh;
    return full[63:0];
  endfunction

  // lcg state that steps to target, using the inverse of the multiplier mod 2^48
  function automatic logic [47:0] seed_before(logic [47:0] target);
    logic [47:0] inv;
    inv = LCG_MULT;
    repeat (5) inv = inv * (48'd2 - LCG_MULT * inv);
    return (target - LCG_INC) * inv;
  endfunction

  // exp(-lambda) threshold table in q0.32, from a q2.60 taylor step
  initial begin
    logic [63:0] d;
    logic [63:0] r;
    logic [63:0] term;
    logic [63:0] e;
    logic [63:0] v;
    d = ((64'd1 << 63) / EXP_TABLE_ENTRIES) << 2;
    r = 64'd1 << 60;
    term = r;
    e = r;
    for (int n = 1; n <= 20; n++) begin
      term = mul_shift(term, d, 60) / n;
      r = (n % 2 == 1) ? r - term : r + term;
    end
    for (int i = 0; i < EXP_TABLE_ENTRIES; i++) begin
      v = (e + (64'd1 << 27)) >> 28;
      exp_table[i] = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
      e = mul_shift(e, r, 60);
    end
  end

  // number of spikes one sample fires; advances the lcg copy
  function automatic int draw_spikes(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] smp);
    logic [15:0] u;
    longint      rate;
    logic [63:0] lam;
    logic [63:0] idx;
    logic [63:0] thr;
    logic [63:0] p;
    int          n;
    bit          done;
    if (ch >= CHANNELS) return 0;
    u = smp ^ 16'h8000;
    rate = longint'(m_rate_min) * 65536
         + longint'(u) * (longint'(m_rate_max) - longint'(m_rate_min));
    if (rate < 0) rate = 0;
    lam = rate;
    lam = (lam * m_step + 64'd500000) / 64'd1000000;
    if (lam > 64'hFF_FFFF) lam = 64'hFF_FFFF;
    idx = (lam * EXP_TABLE_ENTRIES) >> SPAN_SHIFT;
    thr = 64'd0;
    if (idx < EXP_TABLE_ENTRIES) thr = {16'd0, exp_table[idx[ROM_AW-1:0]], 16'd0};
    p = 64'd1 << 48;
    n = 0;
    done = 1'b0;
    while (!done && n < MAX_SPIKES) begin
      m_lcg = LCG_MULT * m_lcg + LCG_INC;
      p = mul_shift(p, {16'd0, m_lcg}, 48);
      if (p > thr) n++;
      else done = 1'b1;
    end
    return n;
  endfunction

  task automatic flag_mismatch(input string msg);
    errors++;
    $display("%0t mismatch: %s", $time, msg);
  endtask

  always @(posedge clk) spike_stall <= ($urandom_range(99) < stall_pct);

  // predictor update, spike checking and watchdog
  always @(posedge clk) begin
    spike_t want;
    int     n;
    if (rst) begin
      m_rate_min = 16'd0;
      m_rate_max = 16'd100;
      m_step = 20'd1000;
      m_lcg = 48'd4660;
      pending_spikes.delete();
      quiet = 0;
    end else begin
      if (cfg_wr_en || (sample_valid && !sample_stall) || (spike_valid && !spike_stall))
        quiet = 0;
      else
        quiet++;
      if (cfg_wr_en) begin
        writes_done++;
        case (cfg_index)
          CFG_RATE_MIN: m_rate_min = cfg_data[15:0];
          CFG_RATE_MAX: m_rate_max = cfg_data[15:0];
          CFG_STEP:     m_step = cfg_data[19:0];
          CFG_SEED:     m_lcg = cfg_data[47:0];
        endcase
      end
      if (sample_valid && !sample_stall) begin
        n = draw_spikes(channel, sample);
        if (typed_count != PREDICTED) n = typed_count;
        for (int k = 0; k < n; k++)
          pending_spikes.push_back(spike_t'{channel, k == n - 1, n == MAX_SPIKES});
        samples_in++;
        if (n == 0) empty_runs++;
        if (n == MAX_SPIKES) capped_runs++;
      end
      if (spike_valid && !spike_stall) begin
        spikes_seen++;
        if (pending_spikes.size() == 0) begin
          flag_mismatch($sformatf("spike on channel %0d with none expected", spike_channel));
        end else begin
          want = pending_spikes.pop_front();
          if (spike_channel !== want.ch)
            flag_mismatch($sformatf("spike_channel %0d, want %0d", spike_channel, want.ch));
          if (spike_last !== want.last)
            flag_mismatch($sformatf("spike_last %b, want %b on channel %0d",
                                    spike_last, want.last, want.ch));
          if (saturated !== want.sat)
            flag_mismatch($sformatf("saturated %b, want %b on channel %0d",
                                    saturated, want.sat, want.ch));
        end
      end
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("poisson_spike_encoder verification failed");
        $finish;
      end
    end
  end

  // caller is at a rising edge; returns at the edge that takes the item
  task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] smp,
                             input int count);
    while ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    channel <= ch;
    sample <= smp;
    typed_count <= count;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
  endtask

  // stop sending, wait for every expected spike, then let the engine go quiet
  task automatic settle(input int extra);
    sample_valid <= 1'b0;
    while (pending_spikes.size() != 0) @(negedge clk);
    @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_idx_t idx, input logic [47:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    stim_row_t   plan [$];
    stim_row_t   row;
    bit          busy;
    logic [47:0] junk;
    logic [15:0] rmin;
    logic [15:0] rmax;
    logic [19:0] step;

    // defaults: 0..100 Hz, 1 ms tick
    plan.push_back('{ROW_SAMPLE, CFG_RATE_MIN, 48'd0, 8'h00, 16'h8000, 0});
    plan.push_back('{ROW_SAMPLE, CFG_RATE_MIN, 48'd0, 8'hFF, 16'h7FFF, PREDICTED});
    plan.push_back('{ROW_SAMPLE, CFG_RATE_MIN, 48'd0, 8'h55, 16'h0000, PREDICTED});
    plan.push_back('{ROW_SAMPLE, CFG_RATE_MIN, 48'd0, 8'hAA, 16'hFFFF, PREDICTED});
    // zero tick length
    plan.push_back('{ROW_WRITE, CFG_STEP, 48'd0, 8'd0, 16'd0, PREDICTED});
    plan.push_back('{ROW_SAMPLE, CFG_RATE_MIN, 48'd0, 8'h01, 16'h7FFF, PREDICTED});
    // huge lambda, threshold zero at the top of the range
    plan.push_back('{ROW_WRITE, CFG_RATE_MAX, 48'd65535, 8'd0, 16'd0, PREDICTED});
    plan.push_back('{ROW_WRITE, CFG_STEP, 48'd1000000, 8'd0, 16'd0, PREDICTED});
    plan.push_back('{ROW_SAMPLE, CFG_RATE_MIN, 48'd0, 8'h80, 16'h7FFF, PREDICTED});
    plan.push_back('{ROW_SAMPLE, CFG_RATE_MIN, 48'd0, 8'h7F, 16'h8000, PREDICTED});
    plan.push_back('{ROW_SAMPLE, CFG_RATE_MIN, 48'd0, 8'h3C, 16'h4000, PREDICTED});
    // max below min: mapping runs downward
    plan.push_back('{ROW_WRITE, CFG_RATE_MIN, 48'd65535, 8'd0, 16'd0, PREDICTED});
    plan.push_back('{ROW_WRITE, CFG_RATE_MAX, 48'd0, 8'd0, 16'd0, PREDICTED});
    plan.push_back('{ROW_SAMPLE, CFG_RATE_MIN, 48'd0, 8'hC3, 16'h8000, PREDICTED});
    plan.push_back('{ROW_SAMPLE, CFG_RATE_MIN, 48'd0, 8'h0F, 16'h7FFF, PREDICTED});
    // next draw is exactly zero: product dies at once, no spike
    plan.push_back('{ROW_WRITE, CFG_SEED, seed_before(48'd0), 8'd0, 16'd0, PREDICTED});
    plan.push_back('{ROW_SAMPLE, CFG_RATE_MIN, 48'd0, 8'hF0, 16'h8000, 0});
    plan.push_back('{ROW_SAMPLE, CFG_RATE_MIN, 48'd0, 8'h5A, 16'h8000, PREDICTED});
    // lambda zero, but the next draw is the largest uniform
    plan.push_back('{ROW_WRITE, CFG_RATE_MIN, 48'd0, 8'd0, 16'd0, PREDICTED});
    plan.push_back('{ROW_WRITE, CFG_SEED, seed_before('1), 8'd0, 16'd0, PREDICTED});
    plan.push_back('{ROW_SAMPLE, CFG_RATE_MIN, 48'd0, 8'hA5, 16'h1234, PREDICTED});
    // shortest tick, full rate span, seed extremes
    plan.push_back('{ROW_WRITE, CFG_STEP, 48'd1, 8'd0, 16'd0, PREDICTED});
    plan.push_back('{ROW_WRITE, CFG_RATE_MAX, 48'd65535, 8'd0, 16'd0, PREDICTED});
    plan.push_back('{ROW_WRITE, CFG_SEED, 48'd0, 8'd0, 16'd0, PREDICTED});
    plan.push_back('{ROW_SAMPLE, CFG_RATE_MIN, 48'd0, 8'h33, 16'h7FFF, PREDICTED});
    plan.push_back('{ROW_SAMPLE, CFG_RATE_MIN, 48'd0, 8'hCC, 16'h8000, PREDICTED});
    plan.push_back('{ROW_WRITE, CFG_SEED, 48'hFFFF_FFFF_FFFF, 8'd0, 16'd0, PREDICTED});
    plan.push_back('{ROW_WRITE, CFG_RATE_MIN, 48'd65535, 8'd0, 16'd0, PREDICTED});
    plan.push_back('{ROW_WRITE, CFG_STEP, 48'd1000, 8'd0, 16'd0, PREDICTED});
    plan.push_back('{ROW_SAMPLE, CFG_RATE_MIN, 48'd0, 8'h99, 16'h0001, PREDICTED});
    plan.push_back('{ROW_SAMPLE, CFG_RATE_MIN, 48'd0, 8'h66, 16'hFFFE, PREDICTED});

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct = 20;
    stall_pct = 20;
    busy = 1'b0;
    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_WRITE) begin
        if (busy) settle(SETTLE_CYCLES);
        busy = 1'b0;
        cfg_write(row.idx, row.value);
      end else begin
        send_sample(row.ch, row.smp, row.count);
        busy = 1'b1;
      end
    end

    for (int ph = 0; ph < 8; ph++) begin
      settle(SETTLE_CYCLES);
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 65; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 65; end
        default: begin send_idle_pct = 20; stall_pct = 20; end
      endcase
      // mostly modest rates so runs stay short, now and then anything
      rmin = ($urandom_range(3) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(1000));
      rmax = ($urandom_range(3) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(20000));
      case ($urandom_range(3))
        0: step = 20'd1000;
        1: step = 20'($urandom_range(1, 20000));
        2: step = 20'($urandom_range(1, 1000000));
        default: step = 20'($urandom_range(1, 200));
      endcase
      // junk above each register's width must be dropped
      junk = 48'({$urandom, $urandom});
      cfg_write(CFG_RATE_MIN, {junk[47:16], rmin});
      junk = 48'({$urandom, $urandom});
      cfg_write(CFG_RATE_MAX, {junk[47:16], rmax});
      junk = 48'({$urandom, $urandom});
      cfg_write(CFG_STEP, {junk[47:20], step});
      junk = 48'({$urandom, $urandom});
      cfg_write(CFG_SEED, junk);
      for (int i = 0; i < 19; i++) begin
        if (i == 10) settle(0);
        send_sample(8'($urandom_range(255)), 16'($urandom_range(65535)), PREDICTED);
      end
    end
    settle(TAIL_CYCLES);

    $display("drove %0d samples (%0d with no spike, %0d at the cap) and %0d register writes",
             samples_in, empty_runs, capped_runs, writes_done);
    $display("checked %0d spikes under four idle/stall mixes, %0d mismatches",
             spikes_seen, errors);
    if (errors == 0) begin
      $display("poisson_spike_encoder verification clean");
    end else begin
      $display("poisson_spike_encoder verification failed");
    end
    $finish;
  end

endmodule
